// ----- rtl/tcp_pkg.sv -----
// Shared types and constants for the turtle command processor.
// Holds the transfer structs, command and kind codes, and the quarter-wave sine table.
// No dependencies.
package tcp_pkg;

	localparam int COORD_WIDTH_DEF    = 16;
	localparam int TRIG_FRAC_BITS_DEF = 14;
	localparam int TABLE_FRAC_BITS    = 14;

	localparam int FIELD_W   = 16;
	localparam int INK_W     = 24;
	localparam int HEAD_W    = 9;
	localparam int CANVAS_W  = 15;
	localparam int CFG_IDX_W = 1;

	localparam int DEG_FULL    = 360;
	localparam int DEG_HALF    = 180;
	localparam int DEG_QUARTER = 90;
	localparam int DEG_3Q      = 270;

	localparam logic [CANVAS_W-1:0] CANVAS_RESET  = 15'd128;
	localparam logic [HEAD_W-1:0]   HEADING_RESET = 9'd90;
	localparam logic [INK_W-1:0]    INK_RESET     = 24'hFFFFFF;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'd1;

	// command codes
	localparam logic [3:0] CMD_FORWARD    = 4'd0;
	localparam logic [3:0] CMD_BACKWARD   = 4'd1;
	localparam logic [3:0] CMD_LEFT       = 4'd2;
	localparam logic [3:0] CMD_RIGHT      = 4'd3;
	localparam logic [3:0] CMD_SETHEADING = 4'd4;
	localparam logic [3:0] CMD_PENUP      = 4'd5;
	localparam logic [3:0] CMD_PENDOWN    = 4'd6;
	localparam logic [3:0] CMD_GOTO       = 4'd7;
	localparam logic [3:0] CMD_HOME       = 4'd8;
	localparam logic [3:0] CMD_COLOUR     = 4'd9;
	localparam logic [3:0] CMD_BEGINFILL  = 4'd10;
	localparam logic [3:0] CMD_ENDFILL    = 4'd11;
	localparam logic [3:0] CMD_QUERY      = 4'd12;

	// draw item kinds
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_RECT  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [3:0]                command;
		logic signed [FIELD_W-1:0] arg_a;
		logic signed [FIELD_W-1:0] arg_b;
		logic [INK_W-1:0]          colour_value;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [FIELD_W-1:0] x_first;
		logic signed [FIELD_W-1:0] y_first;
		logic signed [FIELD_W-1:0] x_second;
		logic signed [FIELD_W-1:0] y_second;
		logic [INK_W-1:0]          ink;
		logic [HEAD_W-1:0]         heading_out;
		logic                      pen_out;
		logic                      last_item;
	} draw_item_t;

	// sin(0..90 deg) in Q1.14
	localparam logic [14:0] QUARTER_SIN [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
		15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
		15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
		15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
		15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
		15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
		15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
		15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
		15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
		15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
		15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

endpackage

// ----- rtl/turtle_command_processor.sv -----
// Turtle command processor top level: command pipeline, turtle state, draw output.
// Depends on tcp_pkg, tcp_sine_scale and tcp_draw_queue.
//
// Usage: commands arrive on the cmd channel (cmd_valid / cmd_stall / cmd); a transfer
// happens at a rising edge with cmd_valid high and cmd_stall low. Draw items leave on
// the draw channel (draw_valid / draw_stall / draw) under the same rule. Lines,
// fill rectangles and query reports come out in command order; last_item marks the
// final item of a command. Most commands produce no item, pen-down moves and queries
// one, end fill up to two.
// An item reaches draw after its command has passed stages 1, 2 and 3 and the queue.
// Throughput: one command per cycle while stage 3 is not held. Stage 1 reduces angles
// mod 360, stage 2 updates the heading and runs the two sine multipliers, stage 3
// updates position, pen, ink and fill box. An end fill that yields two items waits in
// stage 3 until the two-entry output queue is empty, so in a stream of such commands
// each waits until the items of the one before have left the queue.
// Stalls: while draw_stall holds, the queue fills, stage 3 holds its command, and
// cmd_stall rises once the pipeline is full; nothing is dropped.
// Reset (arst_n low): canvas 128 x 128, turtle at (64, 64), heading 90, pen down,
// white ink, no fill; pipeline and queue empty.
// Config: cfg_write with cfg_index / cfg_data sets canvas width or height; a new
// size takes effect at the next home command. Write only while the block is idle.
module turtle_command_processor #(
	parameter int COORD_WIDTH    = tcp_pkg::COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = tcp_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [tcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcp_pkg::CANVAS_W-1:0]  cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  tcp_pkg::cmd_item_t            cmd,
	output logic                          draw_valid,
	input  logic                          draw_stall,
	output tcp_pkg::draw_item_t           draw
);
	import tcp_pkg::*;

	localparam int CW = COORD_WIDTH;

	// a mod 360 via reciprocal: bias keeps the value positive, then
	// floor(u * 46604 / 2^24) is exact for u below 65888
	localparam logic [16:0] ANGLE_BIAS  = 17'd33120;
	localparam logic [32:0] RECIP_360   = 33'd46604;
	localparam int          RECIP_SHIFT = 24;

	// ---------------- configuration ----------------
	logic [CANVAS_W-1:0] canvas_w_q, canvas_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= CANVAS_RESET;
			canvas_h_q <= CANVAS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data;
				CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data;
				default:           canvas_w_q <= canvas_w_q;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic s1_free, s2_free, s3_free;
	logic fire;
	logic [1:0] q_count;
	logic [1:0] res_cnt;

	assign fire      = valid_s3 && (({1'b0, q_count} + {1'b0, res_cnt}) <= 3'd2);
	assign s3_free   = !valid_s3 || fire;
	assign s2_free   = !valid_s2 || s3_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign cmd_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s1_free) valid_s1 <= cmd_valid;
			if (s2_free) valid_s2 <= valid_s1;
			if (s3_free) valid_s3 <= valid_s2;
		end
	end

	// ---------------- stage 1: angle reduction, distance split ----------------
	cmd_item_t item_s1;

	always_ff @(posedge clk) begin
		if (s1_free && cmd_valid) item_s1 <= cmd;
	end

	logic [FIELD_W-1:0] neg_a;
	logic [FIELD_W-1:0] ang_src;
	logic [16:0]        ang_u;
	logic [32:0]        ang_prod;
	logic [8:0]         ang_quo;
	logic [16:0]        ang_sub;
	logic [16:0]        ang_rem;
	logic [FIELD_W-1:0] dist_val;
	logic [FIELD_W-1:0] dist_mag;
	logic               dist_neg;

	always_comb begin
		neg_a    = '0 - item_s1.arg_a;
		ang_src  = (item_s1.command == CMD_RIGHT) ? neg_a : item_s1.arg_a;
		ang_u    = {ang_src[FIELD_W-1], ang_src} + ANGLE_BIAS;
		ang_prod = {16'd0, ang_u} * RECIP_360;
		ang_quo  = ang_prod[32:RECIP_SHIFT];
		ang_sub  = {8'd0, ang_quo} * 17'(DEG_FULL);
		ang_rem  = ang_u - ang_sub;
		dist_val = (item_s1.command == CMD_BACKWARD) ? neg_a : item_s1.arg_a;
		dist_neg = dist_val[FIELD_W-1];
		dist_mag = dist_neg ? ('0 - dist_val) : dist_val;
	end

	cmd_item_t          item_s2;
	logic [HEAD_W-1:0]  ang_s2;
	logic [FIELD_W-1:0] dmag_s2;
	logic               dneg_s2;

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			item_s2 <= item_s1;
			ang_s2  <= ang_rem[HEAD_W-1:0];
			dmag_s2 <= dist_mag;
			dneg_s2 <= dist_neg;
		end
	end

	// ---------------- stage 2: heading, sine multiply ----------------
	logic [HEAD_W-1:0] heading_q;
	logic [HEAD_W-1:0] heading_next;
	logic [HEAD_W:0]   head_sum;
	logic [HEAD_W:0]   head_x_sum;
	logic [HEAD_W-1:0] head_x;
	logic [CW-1:0]     dx, dy;

	always_comb begin
		head_sum = {1'b0, heading_q} + {1'b0, ang_s2};
		if (head_sum >= 10'(DEG_FULL)) head_sum = head_sum - 10'(DEG_FULL);
		unique case (item_s2.command)
			CMD_LEFT, CMD_RIGHT: heading_next = head_sum[HEAD_W-1:0];
			CMD_SETHEADING:      heading_next = ang_s2;
			CMD_HOME:            heading_next = HEADING_RESET;
			default:             heading_next = heading_q;
		endcase
		// x moves with the sine of heading + 90
		head_x_sum = {1'b0, heading_q} + 10'(DEG_QUARTER);
		if (head_x_sum >= 10'(DEG_FULL)) head_x_sum = head_x_sum - 10'(DEG_FULL);
		head_x = head_x_sum[HEAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= HEADING_RESET;
		end else if (valid_s2 && s3_free) begin
			heading_q <= heading_next;
		end
	end

	tcp_sine_scale #(
		.COORD_WIDTH   (COORD_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_sine_x (
		.deg     (head_x),
		.dist_mag(dmag_s2),
		.dist_neg(dneg_s2),
		.delta   (dx)
	);

	tcp_sine_scale #(
		.COORD_WIDTH   (COORD_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_sine_y (
		.deg     (heading_q),
		.dist_mag(dmag_s2),
		.dist_neg(dneg_s2),
		.delta   (dy)
	);

	cmd_item_t         item_s3;
	logic [CW-1:0]     dx_s3, dy_s3;
	logic [HEAD_W-1:0] head_s3;

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			item_s3 <= item_s2;
			dx_s3   <= dx;
			dy_s3   <= dy;
			head_s3 <= heading_next;
		end
	end

	// ---------------- stage 3: turtle state and draw items ----------------
	logic signed [CW-1:0] pos_x_q, pos_y_q;
	logic signed [CW-1:0] start_x_q, start_y_q;
	logic signed [CW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic                 pen_q, fill_q;
	logic [INK_W-1:0]     ink_q;

	function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
		logic [CW+FIELD_W-1:0] w;
		w = {{FIELD_W{1'b0}}, v};
		return w[FIELD_W-1:0];
	endfunction

	logic signed [CW-1:0]  new_x, new_y;
	logic [CW+FIELD_W-1:0] goto_x_ext, goto_y_ext;
	logic [CW+13:0]        home_x_ext, home_y_ext;
	logic signed [CW-1:0]  box_w, box_h;
	logic                  is_move;
	logic                  close_line;
	logic                  rect_ok;
	draw_item_t            line_item, rect_item, res0, res1;

	always_comb begin
		goto_x_ext = {{CW{item_s3.arg_a[FIELD_W-1]}}, item_s3.arg_a};
		goto_y_ext = {{CW{item_s3.arg_b[FIELD_W-1]}}, item_s3.arg_b};
		home_x_ext = {{CW{1'b0}}, canvas_w_q[CANVAS_W-1:1]};
		home_y_ext = {{CW{1'b0}}, canvas_h_q[CANVAS_W-1:1]};
		is_move    = item_s3.command == CMD_FORWARD || item_s3.command == CMD_BACKWARD ||
			item_s3.command == CMD_GOTO;
		if (item_s3.command == CMD_GOTO) begin
			new_x = goto_x_ext[CW-1:0];
			new_y = goto_y_ext[CW-1:0];
		end else begin
			new_x = pos_x_q + dx_s3;
			new_y = pos_y_q + dy_s3;
		end

		box_w      = max_x_q - min_x_q + CW'(1);
		box_h      = max_y_q - min_y_q + CW'(1);
		close_line = pen_q && (pos_x_q != start_x_q || pos_y_q != start_y_q);
		rect_ok    = !box_w[CW-1] && box_w != '0 && !box_h[CW-1] && box_h != '0;

		line_item = '0;
		line_item.kind = KIND_LINE;
		line_item.x_first = to_field(pos_x_q);
		line_item.y_first = to_field(pos_y_q);
		line_item.ink = ink_q;
		line_item.last_item = 1'b1;
		if (is_move) begin
			line_item.x_second = to_field(new_x);
			line_item.y_second = to_field(new_y);
		end else begin
			line_item.x_second = to_field(start_x_q);
			line_item.y_second = to_field(start_y_q);
		end

		rect_item = '0;
		rect_item.kind = KIND_RECT;
		rect_item.x_first = to_field(min_x_q);
		rect_item.y_first = to_field(min_y_q);
		rect_item.x_second = to_field(box_w);
		rect_item.y_second = to_field(box_h);
		rect_item.ink = ink_q;
		rect_item.last_item = 1'b1;

		res0    = line_item;
		res1    = rect_item;
		res_cnt = 2'd0;
		unique case (item_s3.command)
			CMD_FORWARD, CMD_BACKWARD, CMD_GOTO: begin
				res_cnt = {1'b0, pen_q};
			end
			CMD_ENDFILL: begin
				if (fill_q) begin
					res_cnt = {1'b0, close_line} + {1'b0, rect_ok};
					if (close_line) begin
						res0.last_item = !rect_ok;
					end else begin
						res0 = rect_item;
					end
				end
			end
			CMD_QUERY: begin
				res0 = '0;
				res0.kind = KIND_QUERY;
				res0.x_first = to_field(pos_x_q);
				res0.y_first = to_field(pos_y_q);
				res0.ink = ink_q;
				res0.heading_out = head_s3;
				res0.pen_out = pen_q;
				res0.last_item = 1'b1;
				res_cnt = 2'd1;
			end
			default: res_cnt = 2'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= CW'(CANVAS_RESET >> 1);
			pos_y_q   <= CW'(CANVAS_RESET >> 1);
			pen_q     <= 1'b1;
			fill_q    <= 1'b0;
			ink_q     <= INK_RESET;
			start_x_q <= '0;
			start_y_q <= '0;
			min_x_q   <= '0;
			max_x_q   <= '0;
			min_y_q   <= '0;
			max_y_q   <= '0;
		end else if (fire) begin
			unique case (item_s3.command)
				CMD_FORWARD, CMD_BACKWARD, CMD_GOTO: begin
					pos_x_q <= new_x;
					pos_y_q <= new_y;
					if (fill_q) begin
						if (new_x < min_x_q) min_x_q <= new_x;
						if (new_x > max_x_q) max_x_q <= new_x;
						if (new_y < min_y_q) min_y_q <= new_y;
						if (new_y > max_y_q) max_y_q <= new_y;
					end
				end
				CMD_PENUP:   pen_q <= 1'b0;
				CMD_PENDOWN: pen_q <= 1'b1;
				CMD_HOME: begin
					pos_x_q <= home_x_ext[CW-1:0];
					pos_y_q <= home_y_ext[CW-1:0];
				end
				CMD_COLOUR: ink_q <= item_s3.colour_value;
				CMD_BEGINFILL: begin
					fill_q    <= 1'b1;
					start_x_q <= pos_x_q;
					start_y_q <= pos_y_q;
					min_x_q   <= pos_x_q;
					max_x_q   <= pos_x_q;
					min_y_q   <= pos_y_q;
					max_y_q   <= pos_y_q;
				end
				CMD_ENDFILL: fill_q <= 1'b0;
				default:     fill_q <= fill_q;
			endcase
		end
	end

	// ---------------- output queue ----------------
	tcp_draw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (fire ? res_cnt : 2'd0),
		.push_first (res0),
		.push_second(res1),
		.fill_cnt   (q_count),
		.draw_valid (draw_valid),
		.draw_stall (draw_stall),
		.draw       (draw)
	);

	// ---------------- assertions ----------------
	a_pair_needs_empty_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_cnt == 2'd2) |-> q_count == 2'd0)
		else $error("two draw items pushed into a non-empty queue");

	a_pair_only_endfill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && res_cnt == 2'd2) |-> item_s3.command == CMD_ENDFILL)
		else $error("two draw items from a command other than end fill");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_q < HEAD_W'(DEG_FULL))
		else $error("heading out of range");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !fire) |=> (valid_s3 && $stable(item_s3)))
		else $error("stage 3 command lost while waiting for queue space");

	a_draw_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(draw_valid) |-> $past(!draw_stall))
		else $error("draw item vanished without a transfer");

endmodule

// ----- rtl/tcp_sine_scale.sv -----
// Move delta along one axis: sine lookup, fraction rescale, distance multiply.
// Uses tcp_pkg (sine table, degree constants).
module tcp_sine_scale #(
	parameter int COORD_WIDTH    = tcp_pkg::COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = tcp_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic [tcp_pkg::HEAD_W-1:0]  deg,
	input  logic [tcp_pkg::FIELD_W-1:0] dist_mag,
	input  logic                        dist_neg,
	output logic [COORD_WIDTH-1:0]      delta
);
	import tcp_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 1;
	localparam int PW = TW + FIELD_W;
	localparam int MW = PW - TRIG_FRAC_BITS;
	localparam int EW = COORD_WIDTH + MW;

	logic              neg;
	logic [6:0]        idx;
	logic [14:0]       raw;
	logic [TW-1:0]     trig;
	logic [PW-1:0]     prod;
	logic [MW-1:0]     mag;
	logic [EW-1:0]     mag_ext;
	logic [EW-1:0]     signed_ext;

	always_comb begin
		neg = deg > HEAD_W'(DEG_HALF);
		if (deg <= HEAD_W'(DEG_QUARTER)) begin
			idx = deg[6:0];
		end else if (deg <= HEAD_W'(DEG_HALF)) begin
			idx = 7'(HEAD_W'(DEG_HALF) - deg);
		end else if (deg <= HEAD_W'(DEG_3Q)) begin
			idx = 7'(deg - HEAD_W'(DEG_HALF));
		end else begin
			idx = 7'(HEAD_W'(DEG_FULL) - deg);
		end
		raw = QUARTER_SIN[idx];
	end

	generate
		if (TRIG_FRAC_BITS >= TABLE_FRAC_BITS) begin : g_up
			assign trig = TW'(raw) << (TRIG_FRAC_BITS - TABLE_FRAC_BITS);
		end else begin : g_down
			localparam int DN = TABLE_FRAC_BITS - TRIG_FRAC_BITS;
			logic [15:0] rounded;
			// round half up
			assign rounded = ({1'b0, raw} + 16'(1 << (DN - 1))) >> DN;
			assign trig    = rounded[TW-1:0];
		end
	endgenerate

	always_comb begin
		prod       = PW'(trig) * PW'(dist_mag);
		mag        = prod[PW-1:TRIG_FRAC_BITS];
		mag_ext    = EW'(mag);
		signed_ext = (neg ^ dist_neg) ? ('0 - mag_ext) : mag_ext;
		delta      = signed_ext[COORD_WIDTH-1:0];
	end

endmodule

// ----- rtl/tcp_draw_queue.sv -----
// Two-entry output queue for draw items; takes up to two items per cycle, two only when it is empty after the pop.
// Uses tcp_pkg (draw_item_t).
module tcp_draw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  tcp_pkg::draw_item_t push_first,
	input  tcp_pkg::draw_item_t push_second,
	output logic [1:0]          fill_cnt,
	output logic                draw_valid,
	input  logic                draw_stall,
	output tcp_pkg::draw_item_t draw
);
	import tcp_pkg::*;

	draw_item_t slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] cnt_after;

	always_comb begin
		pop       = (cnt_q != 2'd0) && !draw_stall;
		cnt_after = cnt_q - {1'b0, pop};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_after + push_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_after == 2'd0 && push_cnt != 2'd0) begin
			slot0_q <= push_first;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
		if (cnt_after == 2'd0 && push_cnt == 2'd2) begin
			slot1_q <= push_second;
		end else if (cnt_after == 2'd1 && push_cnt != 2'd0) begin
			slot1_q <= push_first;
		end
	end

	assign fill_cnt   = cnt_q;
	assign draw_valid = cnt_q != 2'd0;
	assign draw       = slot0_q;

endmodule
